### sv/vra_pkg.sv
`default_nettype none

package vra_pkg;

  // Geometry limits
  localparam int unsigned MaxDim    = 1024;
  localparam int unsigned CntW      = $clog2(MaxDim);       // coordinate counter
  localparam int unsigned DimW      = CntW + 1;             // extent, holds MaxDim
  localparam int unsigned StrideW   = 2 * DimW - 1;         // extent product
  localparam int unsigned MaxComp   = 4;
  localparam int unsigned CompW     = 2;
  localparam int unsigned NcompW    = CompW + 1;            // holds MaxComp

  // Port widths
  localparam int unsigned SizeW     = 11;
  localparam int unsigned AxisW     = 2;
  localparam int unsigned FlipW     = 3;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned IdxW      = 30;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OUT_AXIS_X = 3'd0,
    REG_OUT_AXIS_Y = 3'd1,
    REG_OUT_AXIS_Z = 3'd2,
    REG_FLIP_MASK  = 3'd3,
    REG_SIZE_X     = 3'd4,
    REG_SIZE_Y     = 3'd5,
    REG_SIZE_Z     = 3'd6,
    REG_NUM_COMP   = 3'd7
  } reg_idx_e;

  // Input axis codes; the spare code falls back to x
  localparam logic [AxisW-1:0] AXIS_X = 2'd0;
  localparam logic [AxisW-1:0] AXIS_Y = 2'd1;
  localparam logic [AxisW-1:0] AXIS_Z = 2'd2;

  // Effective (clamped) geometry
  typedef struct packed {
    logic [2:0][DimW-1:0] size;
    logic [NcompW-1:0]    ncomp;
  } geom_t;

  // Raster position of the current sample
  typedef struct packed {
    logic [CompW-1:0] comp;
    logic [CntW-1:0]  x;
    logic [CntW-1:0]  y;
    logic [CntW-1:0]  z;
  } cnt_t;

  // First pipeline stage payload
  typedef struct packed {
    logic [2:0][DimW-1:0] oc;      // output coords, two's complement
    logic [1:0][DimW-1:0] odim;    // output extents of axes 0 and 1
    logic [CompW-1:0]     comp;
    logic                 last;
    logic [SampleW-1:0]   sample;
  } s1_t;

  function automatic logic [DimW-1:0] eff_size(input logic [SizeW-1:0] raw);
    logic [DimW-1:0] res;
    if (raw == '0) begin
      res = DimW'(1);
    end else if (raw > SizeW'(MaxDim)) begin
      res = DimW'(MaxDim);
    end else begin
      res = DimW'(raw);
    end
    return res;
  endfunction

  function automatic logic [NcompW-1:0] eff_comps(input logic [NcompW-1:0] raw);
    logic [NcompW-1:0] res;
    if (raw == '0) begin
      res = NcompW'(1);
    end else if (raw > NcompW'(MaxComp)) begin
      res = NcompW'(MaxComp);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/vra_raster_cnt.sv
`default_nettype none

module vra_raster_cnt (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  vra_pkg::geom_t     geom_i,
  output vra_pkg::cnt_t      cnt_o,
  output logic               last_o
);

  vra_pkg::cnt_t cnt_q, cnt_d;
  logic comp_end, x_end, y_end, z_end;

  // ">=" so a counter left past a shrunken extent wraps on its next step
  assign comp_end = {1'b0, cnt_q.comp} >= (geom_i.ncomp - vra_pkg::NcompW'(1));
  assign x_end    = {1'b0, cnt_q.x} >= (geom_i.size[0] - vra_pkg::DimW'(1));
  assign y_end    = {1'b0, cnt_q.y} >= (geom_i.size[1] - vra_pkg::DimW'(1));
  assign z_end    = {1'b0, cnt_q.z} >= (geom_i.size[2] - vra_pkg::DimW'(1));

  assign last_o = comp_end && x_end && y_end && z_end;
  assign cnt_o  = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (!comp_end) begin
      cnt_d.comp = cnt_q.comp + vra_pkg::CompW'(1);
    end else begin
      cnt_d.comp = '0;
      if (!x_end) begin
        cnt_d.x = cnt_q.x + vra_pkg::CntW'(1);
      end else begin
        cnt_d.x = '0;
        if (!y_end) begin
          cnt_d.y = cnt_q.y + vra_pkg::CntW'(1);
        end else begin
          cnt_d.y = '0;
          if (!z_end) begin
            cnt_d.z = cnt_q.z + vra_pkg::CntW'(1);
          end else begin
            cnt_d.z = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (adv_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### sv/vra_axis_map.sv
`default_nettype none

module vra_axis_map (
  input  vra_pkg::cnt_t                               cnt_i,
  input  vra_pkg::geom_t                              geom_i,
  input  wire logic [2:0][vra_pkg::AxisW-1:0]         axis_i,
  input  wire logic [vra_pkg::FlipW-1:0]              flip_i,
  output logic      [2:0][vra_pkg::DimW-1:0]          oc_o,
  output logic      [1:0][vra_pkg::DimW-1:0]          odim_o
);

  logic [2:0][vra_pkg::DimW-1:0] dim;
  logic [2:0][vra_pkg::DimW-1:0] coord;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      case (axis_i[j])
        vra_pkg::AXIS_Y: begin
          dim[j]   = geom_i.size[1];
          coord[j] = {1'b0, cnt_i.y};
        end
        vra_pkg::AXIS_Z: begin
          dim[j]   = geom_i.size[2];
          coord[j] = {1'b0, cnt_i.z};
        end
        default: begin
          dim[j]   = geom_i.size[0];
          coord[j] = {1'b0, cnt_i.x};
        end
      endcase
      // reversed coord may go negative; kept as two's complement
      if (flip_i[j]) begin
        oc_o[j] = dim[j] - vra_pkg::DimW'(1) - coord[j];
      end else begin
        oc_o[j] = coord[j];
      end
    end
  end

  assign odim_o[0] = dim[0];
  assign odim_o[1] = dim[1];

endmodule

`default_nettype wire

### sv/vra_index_pipe.sv
`default_nettype none

module vra_index_pipe (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  vra_pkg::s1_t                      s1_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [vra_pkg::IdxW-1:0]          voxel_index_o,
  output logic [vra_pkg::CompW-1:0]         component_o,
  output logic [vra_pkg::SampleW-1:0]       value_o,
  output logic                              last_of_volume_o
);

  localparam int unsigned ExtW = vra_pkg::IdxW - vra_pkg::DimW;

  logic v2_q, v3_q;
  logic rdy2, rdy3;

  // stage 2: row part of the index and plane stride
  logic [vra_pkg::IdxW-1:0]     oc0_ext, oc1_ext, oc2_ext;
  logic [vra_pkg::IdxW-1:0]     part_d, part_q;
  logic [vra_pkg::StrideW-1:0]  stride_d, stride_q;
  logic [vra_pkg::DimW-1:0]     oc2_q;
  logic [vra_pkg::CompW-1:0]    comp2_q;
  logic                         last2_q;
  logic [vra_pkg::SampleW-1:0]  sample2_q;

  // stage 3: full index
  logic [vra_pkg::IdxW-1:0]     idx_d, idx_q;
  logic [vra_pkg::CompW-1:0]    comp3_q;
  logic                         last3_q;
  logic [vra_pkg::SampleW-1:0]  sample3_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  assign oc0_ext = {{ExtW{s1_i.oc[0][vra_pkg::DimW-1]}}, s1_i.oc[0]};
  assign oc1_ext = {{ExtW{s1_i.oc[1][vra_pkg::DimW-1]}}, s1_i.oc[1]};
  assign part_d  = oc0_ext + oc1_ext * vra_pkg::IdxW'(s1_i.odim[0]);
  assign stride_d = vra_pkg::StrideW'(s1_i.odim[0]) * vra_pkg::StrideW'(s1_i.odim[1]);

  assign oc2_ext = {{ExtW{oc2_q[vra_pkg::DimW-1]}}, oc2_q};
  assign idx_d   = part_q + oc2_ext * vra_pkg::IdxW'(stride_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      part_q    <= part_d;
      stride_q  <= stride_d;
      oc2_q     <= s1_i.oc[2];
      comp2_q   <= s1_i.comp;
      last2_q   <= s1_i.last;
      sample2_q <= s1_i.sample;
    end
    if (rdy3 && v2_q) begin
      idx_q     <= idx_d;
      comp3_q   <= comp2_q;
      last3_q   <= last2_q;
      sample3_q <= sample2_q;
    end
  end

  assign out_valid_o      = v3_q;
  assign voxel_index_o    = idx_q;
  assign component_o      = comp3_q;
  assign value_o          = sample3_q;
  assign last_of_volume_o = last3_q;

endmodule

`default_nettype wire

### sv/volume_reorient_address_generator.sv
// Volume reorientation address generator.
// Input channel: one sample beat per voxel component, raster order with the
// component fastest, then x, y and z. Each beat yields one result beat with
// the linear voxel index in the reoriented volume, the component number, the
// sample unchanged and a flag on the last sample of the volume.
// Configuration: write port cfg_we_i / cfg_idx_i / cfg_wdata_i, one register
// per cycle, no read-back. Axis selectors, flip mask, extents and component
// count are meant to change only while no beat is in flight.
// Throughput: one beat per clock, sustained while out_ready_i is high.
// Pipeline: three register stages (input stage register, row-index/stride
// multiply stage, plane multiply stage that is the output register); a
// sample passes through them in that order before out_valid_o rises.
// Stall: out_ready_i low holds the output register; ready propagates back so
// upstream keeps flowing until all three stages are full, then in_ready_o
// drops. Raster counters advance only on accepted beats and wrap to zero
// after the last sample of the volume.
// Reset: registers return to identity axes, no flips, 1x1x1 extents, one
// component; counters and all stage valids clear.
`default_nettype none

module volume_reorient_address_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [vra_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [vra_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // sample input
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [vra_pkg::SampleW-1:0]       sample_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [vra_pkg::IdxW-1:0]               voxel_index_o,
  output logic [vra_pkg::CompW-1:0]              component_o,
  output logic [vra_pkg::SampleW-1:0]            value_o,
  output logic                                   last_of_volume_o
);

  // Configuration registers
  logic [2:0][vra_pkg::AxisW-1:0]  axis_q;
  logic [vra_pkg::FlipW-1:0]       flip_q;
  logic [2:0][vra_pkg::SizeW-1:0]  size_q;
  logic [vra_pkg::NcompW-1:0]      ncomp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q[0] <= vra_pkg::AXIS_X;
      axis_q[1] <= vra_pkg::AXIS_Y;
      axis_q[2] <= vra_pkg::AXIS_Z;
      flip_q    <= '0;
      size_q[0] <= vra_pkg::SizeW'(1);
      size_q[1] <= vra_pkg::SizeW'(1);
      size_q[2] <= vra_pkg::SizeW'(1);
      ncomp_q   <= vra_pkg::NcompW'(1);
    end else if (cfg_we_i) begin
      unique case (vra_pkg::reg_idx_e'(cfg_idx_i))
        vra_pkg::REG_OUT_AXIS_X: axis_q[0] <= cfg_wdata_i[vra_pkg::AxisW-1:0];
        vra_pkg::REG_OUT_AXIS_Y: axis_q[1] <= cfg_wdata_i[vra_pkg::AxisW-1:0];
        vra_pkg::REG_OUT_AXIS_Z: axis_q[2] <= cfg_wdata_i[vra_pkg::AxisW-1:0];
        vra_pkg::REG_FLIP_MASK:  flip_q    <= cfg_wdata_i[vra_pkg::FlipW-1:0];
        vra_pkg::REG_SIZE_X:     size_q[0] <= cfg_wdata_i[vra_pkg::SizeW-1:0];
        vra_pkg::REG_SIZE_Y:     size_q[1] <= cfg_wdata_i[vra_pkg::SizeW-1:0];
        vra_pkg::REG_SIZE_Z:     size_q[2] <= cfg_wdata_i[vra_pkg::SizeW-1:0];
        vra_pkg::REG_NUM_COMP:   ncomp_q   <= cfg_wdata_i[vra_pkg::NcompW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry: zero reads as one, oversize saturates
  vra_pkg::geom_t geom;

  assign geom.size[0] = vra_pkg::eff_size(size_q[0]);
  assign geom.size[1] = vra_pkg::eff_size(size_q[1]);
  assign geom.size[2] = vra_pkg::eff_size(size_q[2]);
  assign geom.ncomp   = vra_pkg::eff_comps(ncomp_q);

  // Input handshake
  logic s1_valid_q;
  logic pipe_ready;
  logic in_fire;

  assign in_ready_o = !s1_valid_q || pipe_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // Raster position
  vra_pkg::cnt_t cnt;
  logic          last;

  vra_raster_cnt u_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_fire),
    .geom_i (geom),
    .cnt_o  (cnt),
    .last_o (last)
  );

  // Axis permutation and flips
  logic [2:0][vra_pkg::DimW-1:0] oc;
  logic [1:0][vra_pkg::DimW-1:0] odim;

  vra_axis_map u_map (
    .cnt_i  (cnt),
    .geom_i (geom),
    .axis_i (axis_q),
    .flip_i (flip_q),
    .oc_o   (oc),
    .odim_o (odim)
  );

  // Input stage register
  vra_pkg::s1_t s1_d, s1_q;

  assign s1_d.oc     = oc;
  assign s1_d.odim   = odim;
  assign s1_d.comp   = cnt.comp;
  assign s1_d.last   = last;
  assign s1_d.sample = sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // Index arithmetic and output register
  vra_index_pipe u_idx (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s1_valid_q),
    .in_ready_o       (pipe_ready),
    .s1_i             (s1_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .voxel_index_o    (voxel_index_o),
    .component_o      (component_o),
    .value_o          (value_o),
    .last_of_volume_o (last_of_volume_o)
  );

endmodule

`default_nettype wire
